[rtl/core/cbz_pkg.sv]
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared constants, types and command codes for the cubic Bezier fixed-step
// evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

	// Number formats
	localparam int COORD_W   = 24;                 // signed Q15.8 coordinate
	localparam int T_FRAC    = 16;                 // fraction bits of t
	localparam int MAX_STEPS = 64;                 // results per curve at most

	localparam int NUM_PTS   = 4;
	localparam int NUM_AXES  = 3;
	localparam int PT_IDX_W  = $clog2(NUM_PTS);
	localparam int AX_IDX_W  = $clog2(NUM_AXES);

	localparam int STEP_W    = T_FRAC + 1;         // step register, Q1.T
	localparam int T_W       = STEP_W + 1;         // t plus one step
	localparam int M_W       = T_W + 1;            // signed one minus t
	localparam int CNT_W     = $clog2(MAX_STEPS + 1);
	localparam int SQ_W      = 2 * STEP_W;         // signed square of t or m
	localparam int MA_W      = SQ_W;               // multiplier operand a
	localparam int MB_W      = COORD_W;            // multiplier operand b
	localparam int P_W       = MA_W + MB_W;        // full product
	localparam int W_W       = T_FRAC + 2;         // signed Bernstein weight
	localparam int ACC_W     = W_W + COORD_W + 2;  // sum of four products
	localparam int SH_W      = ACC_W - T_FRAC;     // sum after truncation

	localparam longint T_ONE     = longint'(1) << T_FRAC;
	localparam longint LIMIT_NUM = 10001;
	localparam longint LIMIT_DEN = 10000;
	// largest t that passes t < 1.0001
	localparam longint T_LIMIT_L = (T_ONE * LIMIT_NUM - 1) / LIMIT_DEN;
	localparam logic [T_W-1:0] T_LIMIT = T_W'(T_LIMIT_L);

	localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(4096);
	localparam logic [PT_IDX_W-1:0] POINT_END  = PT_IDX_W'(NUM_PTS - 1);

	typedef logic signed [COORD_W-1:0] coord_t;

	// Multiplier operations of one curve point, in issue order
	typedef enum logic [4:0] {
		OP_M2, OP_T2, OP_P0, OP_P1, OP_P2, OP_P3,
		OP_X0, OP_X1, OP_X2, OP_X3,
		OP_Y0, OP_Y1, OP_Y2, OP_Y3,
		OP_Z0, OP_Z1, OP_Z2, OP_Z3
	} op_t;

	typedef struct packed {
		logic store;    // write the incoming point
		logic start;    // begin a run at t = step
		logic issue;    // issue op to the multiplier
		op_t  op;
		logic advance;  // load output register, step t
	} cmd_t;

	typedef struct packed {
		logic start_ok; // first t passes the limit
		logic last;     // current point is the final one
	} sts_t;

endpackage

[rtl/core/cbz_ifs.sv]
// ----------------------------------------------------------------------------
// cbz channel interfaces
// Valid/ready channels for configuration, control points and curve points.
// ----------------------------------------------------------------------------
interface cbz_cfg_if import cbz_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STEP_W-1:0] step_fraction;

	modport source (output valid, output step_fraction, input ready);
	modport sink (input valid, input step_fraction, output ready);
endinterface

interface cbz_pt_if import cbz_pkg::*;;
	logic                valid;
	logic                ready;
	logic [PT_IDX_W-1:0] point_index;
	coord_t              coord_x;
	coord_t              coord_y;
	coord_t              coord_z;

	modport source (output valid, output point_index, output coord_x, output coord_y,
		output coord_z, input ready);
	modport sink (input valid, input point_index, input coord_x, input coord_y,
		input coord_z, output ready);
endinterface

interface cbz_crv_if import cbz_pkg::*;;
	logic             valid;
	logic             ready;
	coord_t           curve_x;
	coord_t           curve_y;
	coord_t           curve_z;
	logic [CNT_W-1:0] step_number;
	logic             curve_end;

	modport source (output valid, output curve_x, output curve_y, output curve_z,
		output step_number, output curve_end, input ready);
	modport sink (input valid, input curve_x, input curve_y, input curve_z,
		input step_number, input curve_end, output ready);
endinterface

[rtl/core/cubic_bezier_fixed_step_unit.sv]
// ----------------------------------------------------------------------------
// cubic_bezier_fixed_step_unit
// Fixed-step evaluator of a 3D cubic Bezier curve.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : write channel for the step of t (unsigned Q1.16), taken at once;
//            write it only while no curve is being evaluated.
//   points : one control point per item (index 0..3, signed Q15.8 x, y, z).
//            Points 0..2 are only stored. Point 3 is stored and starts
//            a run over t = step, 2*step, ... while t < 1.0001, at most 64
//            points; points is not ready until the last result is loaded.
//   curve  : one item per curve point with its ordinal and a last flag.
// Operation: each curve point is computed on the single shared multiplier,
//   which performs 18 products per point (6 for the weights, 12 for the
//   coordinates), followed by write-back and output load.
// Reset: step returns to 4096 (1/16), the block is idle, stored points are
//   undefined until written.
// Stall: a finished point waits in the output register while the next one is
//   computed; that one is then held until the register frees.
// ----------------------------------------------------------------------------
module cubic_bezier_fixed_step_unit import cbz_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cbz_cfg_if.sink    cfg,
	cbz_pt_if.sink     points,
	cbz_crv_if.source  curve
);

	cmd_t cmd;
	sts_t sts;

	// Configuration is always taken
	assign cfg.ready = 1'b1;

	cbz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (points.valid),
		.in_index  (points.point_index),
		.in_ready  (points.ready),
		.out_valid (curve.valid),
		.out_ready (curve.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbz_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid),
		.cfg_step    (cfg.step_fraction),
		.in_index    (points.point_index),
		.in_x        (points.coord_x),
		.in_y        (points.coord_y),
		.in_z        (points.coord_z),
		.cmd         (cmd),
		.sts         (sts),
		.curve_x     (curve.curve_x),
		.curve_y     (curve.curve_y),
		.curve_z     (curve.curve_z),
		.step_number (curve.step_number),
		.curve_end   (curve.curve_end)
	);

endmodule

[rtl/core/cbz_dp.sv]
// ----------------------------------------------------------------------------
// cbz_dp
// Datapath: control point store, t stepping, one shared signed multiplier,
// weight formation, accumulation with saturation and the output register.
// ----------------------------------------------------------------------------
module cbz_dp import cbz_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [STEP_W-1:0]   cfg_step,
	input  logic [PT_IDX_W-1:0] in_index,
	input  coord_t              in_x,
	input  coord_t              in_y,
	input  coord_t              in_z,
	input  cmd_t                cmd,
	output sts_t                sts,
	output coord_t              curve_x,
	output coord_t              curve_y,
	output coord_t              curve_z,
	output logic [CNT_W-1:0]    step_number,
	output logic                curve_end
);

	localparam logic signed [M_W-1:0] M_ONE = M_W'(T_ONE);
	localparam logic [PT_IDX_W-1:0] TERM_FIRST = '0;
	localparam logic [PT_IDX_W-1:0] TERM_LAST  = PT_IDX_W'(NUM_PTS - 1);

	logic [STEP_W-1:0]          step_q;
	logic [T_W-1:0]             t_q;
	logic signed [M_W-1:0]      m_q;
	logic [CNT_W-1:0]           n_q;
	coord_t                     pts_q [NUM_PTS][NUM_AXES];
	logic signed [SQ_W-1:0]     m2_q;
	logic signed [SQ_W-1:0]     t2_q;
	logic signed [W_W-1:0]      w_q [NUM_PTS];
	logic signed [ACC_W-1:0]    acc_q;
	coord_t                     res_q [NUM_AXES];

	logic                       wb_s1;
	op_t                        op_s1;
	logic signed [P_W-1:0]      prod_s1;

	logic [T_W-1:0]             next_t;
	logic [3:0]                 k_sel;
	logic [3:0]                 k_wb;
	logic signed [MA_W-1:0]     op_a;
	logic signed [MB_W-1:0]     op_b;
	logic signed [P_W-1:0]      prod;
	logic signed [P_W+1:0]      prod_x3;
	logic signed [W_W-1:0]      w_one;
	logic signed [W_W-1:0]      w_three;
	logic signed [ACC_W-1:0]    sum;
	logic signed [SH_W-1:0]     sum_sh;

	// Clamp a truncated sum into the coordinate range
	function automatic coord_t sat_coord(input logic signed [SH_W-1:0] v);
		logic signed [SH_W-1:0] hi;
		logic signed [SH_W-1:0] lo;
		hi = SH_W'({(COORD_W - 1){1'b1}});
		lo = ~hi;
		if (v > hi) begin
			return COORD_W'(hi);
		end else if (v < lo) begin
			return COORD_W'(lo);
		end
		return COORD_W'(v);
	endfunction

	// Status towards the controller
	assign next_t       = T_W'(t_q + T_W'(step_q));
	assign sts.start_ok = T_W'(step_q) <= T_LIMIT;
	assign sts.last     = (n_q == CNT_W'(MAX_STEPS - 1)) || (next_t > T_LIMIT);

	// Select multiplier operands for the issued op
	assign k_sel = 4'(cmd.op - OP_X0);

	always_comb begin
		case (cmd.op)
			OP_M2: begin
				op_a = MA_W'(m_q);
				op_b = MB_W'(m_q);
			end
			OP_T2: begin
				op_a = MA_W'(t_q);
				op_b = MB_W'(t_q);
			end
			OP_P0: begin
				op_a = m2_q;
				op_b = MB_W'(m_q);
			end
			OP_P1: begin
				op_a = m2_q;
				op_b = MB_W'(t_q);
			end
			OP_P2: begin
				op_a = t2_q;
				op_b = MB_W'(m_q);
			end
			OP_P3: begin
				op_a = t2_q;
				op_b = MB_W'(t_q);
			end
			default: begin
				op_a = MA_W'(w_q[k_sel[PT_IDX_W-1:0]]);
				op_b = pts_q[k_sel[PT_IDX_W-1:0]][k_sel[PT_IDX_W +: AX_IDX_W]];
			end
		endcase
	end

	assign prod = op_a * op_b;

	// Weight formation and accumulation on the registered product
	assign k_wb    = 4'(op_s1 - OP_X0);
	assign prod_x3 = (P_W + 2)'(prod_s1) + ((P_W + 2)'(prod_s1) <<< 1);
	assign w_one   = prod_s1[2 * T_FRAC +: W_W];
	assign w_three = prod_x3[2 * T_FRAC +: W_W];
	assign sum     = acc_q + prod_s1[ACC_W-1:0];
	assign sum_sh  = sum[ACC_W-1:T_FRAC];

	// Hold configuration, t, count and the product tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			t_q    <= '0;
			n_q    <= '0;
			wb_s1  <= 1'b0;
			op_s1  <= OP_M2;
		end else begin
			if (cfg_valid) begin
				step_q <= cfg_step;
			end
			if (cmd.start) begin
				t_q <= T_W'(step_q);
				n_q <= '0;
			end else if (cmd.advance) begin
				t_q <= next_t;
				n_q <= CNT_W'(n_q + 1'b1);
			end
			wb_s1 <= cmd.issue;
			op_s1 <= cmd.op;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			pts_q[in_index][0] <= in_x;
			pts_q[in_index][1] <= in_y;
			pts_q[in_index][2] <= in_z;
		end
		if (cmd.start) begin
			m_q <= M_ONE - M_W'(step_q);
		end else if (cmd.advance) begin
			m_q <= M_ONE - M_W'(next_t);
		end
		prod_s1 <= prod;
		if (wb_s1) begin
			case (op_s1)
				OP_M2: m2_q <= prod_s1[SQ_W-1:0];
				OP_T2: t2_q <= prod_s1[SQ_W-1:0];
				OP_P0: w_q[0] <= w_one;
				OP_P1: w_q[1] <= w_three;
				OP_P2: w_q[2] <= w_three;
				OP_P3: w_q[3] <= w_one;
				default: begin
					if (k_wb[PT_IDX_W-1:0] == TERM_FIRST) begin
						acc_q <= prod_s1[ACC_W-1:0];
					end else if (k_wb[PT_IDX_W-1:0] == TERM_LAST) begin
						res_q[k_wb[PT_IDX_W +: AX_IDX_W]] <= sat_coord(sum_sh);
					end else begin
						acc_q <= sum;
					end
				end
			endcase
		end
		if (cmd.advance) begin
			curve_x     <= res_q[0];
			curve_y     <= res_q[1];
			curve_z     <= res_q[2];
			step_number <= CNT_W'(n_q + 1'b1);
			curve_end   <= sts.last;
		end
	end

	// t stays within the limit while a point is being worked out
	a_t_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> t_q <= T_LIMIT)
		else $error("cbz_dp: t beyond limit during evaluation");

	// no more results than the step bound
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> n_q < CNT_W'(MAX_STEPS))
		else $error("cbz_dp: step count overrun");

endmodule

[rtl/core/cbz_ctrl.sv]
// ----------------------------------------------------------------------------
// cbz_ctrl
// Controller: accepts control points, sequences the eighteen multiplier ops
// of each curve point and manages the output register handshake.
// ----------------------------------------------------------------------------
module cbz_ctrl import cbz_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [PT_IDX_W-1:0] in_index,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  sts_t                sts,
	output cmd_t                cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WB,
		ST_EMIT
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;

	// Commands towards the datapath
	assign in_ready    = state_q == ST_IDLE;
	assign in_acc      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;

	assign cmd.store   = in_acc;
	assign cmd.start   = in_acc && (in_index == POINT_END) && sts.start_ok;
	assign cmd.issue   = state_q == ST_CALC;
	assign cmd.op      = op_q;
	assign cmd.advance = (state_q == ST_EMIT) && out_free;

	// Sequence one curve point after another
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_M2;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_CALC;
						op_q    <= OP_M2;
					end
				end
				ST_CALC: begin
					if (op_q == OP_Z3) begin
						state_q <= ST_WB;
					end else begin
						op_q <= op_t'(op_q + 1'b1);
					end
				end
				ST_WB: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						op_q    <= OP_M2;
						state_q <= sts.last ? ST_IDLE : ST_CALC;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ops of one point issue without gaps
	a_ops_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.op != OP_Z3) |=> cmd.issue)
		else $error("cbz_ctrl: gap in op sequence");

	// the final product is written back before the result is offered
	a_z3_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.op == OP_Z3) |=> ##1 (state_q == ST_EMIT))
		else $error("cbz_ctrl: emit not reached after last op");

endmodule
